[rtl/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[rtl/dvpd_pkg.sv]
package dvpd_pkg;

    typedef enum logic [1:0] {
        KIND_POSITION = 2'd0,
        KIND_TOO_LONG = 2'd1,
        KIND_CLOSED   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       list_end;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] position;
        t_kind       kind;
        logic        last_of_list;
    } t_out_beat;

    localparam int MoreBit = 7;
    localparam logic [2:0] LastIndex = 3'd4;

    // place seven payload bits at the slot of byte idx, bits above 31 dropped
    function automatic logic [31:0] place_payload(input logic [6:0] payload,
                                                  input logic [2:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                3'd0:    v = {25'd0, payload};
                3'd1:    v = {18'd0, payload, 7'd0};
                3'd2:    v = {11'd0, payload, 14'd0};
                3'd3:    v = {4'd0, payload, 21'd0};
                default: v = {payload[3:0], 28'd0};
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/delta_varint_posting_decoder_unit.sv]
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_data  (data_byte, list_end)
// out       output     o_out_valid / i_out_stall  o_out_data (position, kind, last_of_list)
//
// one byte per cycle unless out stalls; a byte is staged, then its result registered
// the varint shift/or and the 32-bit running add sit between input and result registers
// bytes that produce no result are consumed without an output beat
// i_rst_n is synchronous, active low, and clears all decode state and both valid flags
// a stall on out backs up through the result register to o_in_stall in the same cycle
`include "assert_macros.svh"

module delta_varint_posting_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dvpd_pkg::t_in_beat  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dvpd_pkg::t_out_beat o_out_data,
    input  logic                i_out_stall
);

    logic                stage_valid;
    dvpd_pkg::t_in_beat  stage_data;
    logic                out_free;
    logic                advance;
    logic                res_valid;
    dvpd_pkg::t_out_beat res;
    logic                out_err;
    logic                out_closed;

    // the staged byte moves on whenever the result register can take its beat
    assign advance = stage_valid && out_free;

    dvpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_stall   (o_in_stall),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_data    (stage_data)
    );

    dvpd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_data      (stage_data),
        .i_advance   (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dvpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_stall     (i_out_stall)
    );

    assign out_err    = o_out_valid && (o_out_data.kind != dvpd_pkg::KIND_POSITION);
    assign out_closed = o_out_valid && (o_out_data.kind == dvpd_pkg::KIND_CLOSED);

    `ASSERT_PROP(a_err_pos_zero, i_clk, i_rst_n, out_err |-> (o_out_data.position == 32'd0))
    `ASSERT_PROP(a_closed_is_last, i_clk, i_rst_n, out_closed |-> o_out_data.last_of_list)
    `ASSERT_NEVER(a_no_stall_when_empty, i_clk, i_rst_n, o_in_stall && !o_out_valid)

endmodule

[rtl/dvpd_in_reg.sv]
module dvpd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dvpd_pkg::t_in_beat i_data,
    output logic              o_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output dvpd_pkg::t_in_beat o_data
);

    logic               r_valid;
    logic               n_valid;
    dvpd_pkg::t_in_beat r_data;
    logic               accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data;
        end
    end

endmodule

[rtl/dvpd_decode.sv]
module dvpd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dvpd_pkg::t_in_beat  i_data,
    input  logic                i_advance,
    output logic                o_res_valid,
    output dvpd_pkg::t_out_beat o_res
);

    logic [31:0] r_partial;
    logic [31:0] n_partial;
    logic [2:0]  r_byte_index;
    logic [2:0]  n_byte_index;
    logic [31:0] r_running;
    logic [31:0] n_running;
    logic        r_discarding;
    logic        n_discarding;

    logic [2:0]  idx;
    logic        more;
    logic        at_last;
    logic [31:0] gathered;
    logic [31:0] sum;

    assign idx      = (r_byte_index > dvpd_pkg::LastIndex) ? dvpd_pkg::LastIndex
                                                            : r_byte_index;
    assign more     = i_data.data_byte[dvpd_pkg::MoreBit];
    assign at_last  = (idx == dvpd_pkg::LastIndex);
    assign gathered = r_partial | dvpd_pkg::place_payload(i_data.data_byte[6:0], idx);
    assign sum      = r_running + gathered;

    always_comb begin
        n_partial    = r_partial;
        n_byte_index = r_byte_index;
        n_running    = r_running;
        n_discarding = r_discarding;
        o_res_valid  = 1'b0;
        o_res        = '{position: 32'd0, kind: dvpd_pkg::KIND_POSITION,
                         last_of_list: 1'b0};
        if (r_discarding) begin
            if (i_data.list_end) begin
                o_res_valid  = 1'b1;
                o_res.kind   = dvpd_pkg::KIND_CLOSED;
                o_res.last_of_list = 1'b1;
                n_partial    = 32'd0;
                n_byte_index = 3'd0;
                n_running    = 32'd0;
                n_discarding = 1'b0;
            end
        end else if (!more || i_data.list_end) begin
            o_res_valid  = 1'b1;
            n_partial    = 32'd0;
            n_byte_index = 3'd0;
            if (more && at_last) begin
                // fifth byte still continues and closes the list
                o_res.kind         = dvpd_pkg::KIND_TOO_LONG;
                o_res.last_of_list = 1'b1;
                n_running          = 32'd0;
            end else begin
                o_res.position     = sum;
                o_res.last_of_list = i_data.list_end;
                n_running          = i_data.list_end ? 32'd0 : sum;
            end
        end else if (at_last) begin
            o_res_valid  = 1'b1;
            o_res.kind   = dvpd_pkg::KIND_TOO_LONG;
            n_partial    = 32'd0;
            n_byte_index = 3'd0;
            n_discarding = 1'b1;
        end else begin
            n_partial    = gathered;
            n_byte_index = idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial    <= 32'd0;
            r_byte_index <= 3'd0;
            r_running    <= 32'd0;
            r_discarding <= 1'b0;
        end else if (i_valid && i_advance) begin
            r_partial    <= n_partial;
            r_byte_index <= n_byte_index;
            r_running    <= n_running;
            r_discarding <= n_discarding;
        end
    end

endmodule

[rtl/dvpd_out_reg.sv]
module dvpd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_res_valid,
    input  dvpd_pkg::t_out_beat i_res,
    output logic                o_free,
    output logic                o_valid,
    output dvpd_pkg::t_out_beat o_data,
    input  logic                i_stall
);

    logic                r_valid;
    logic                n_valid;
    dvpd_pkg::t_out_beat r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_res_valid;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_data <= i_res;
        end
    end

endmodule

[dv/tb_delta_varint_posting_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_delta_varint_posting_decoder_unit;
    import dvpd_pkg::*;

    localparam int TotalBeats  = 540;
    localparam int HoldCycles  = 300;
    localparam int SettleTicks = 10;
    localparam int CycleLimit  = 200000;

    // running decode of the posting stream and the positions still owed by the block
    class posting_scoreboard;
        logic [31:0] gathered;
        logic [2:0]  slot;
        logic [31:0] list_pos;
        bit          skipping;
        t_out_beat   due_results[$];
        int          mismatches;

        function new();
            restart_list();
            mismatches = 0;
        endfunction

        function void restart_list();
            gathered = '0;
            slot     = '0;
            list_pos = '0;
            skipping = 1'b0;
        endfunction

        function void push_result(logic [31:0] pos, t_kind k, logic last);
            t_out_beat r;
            r.position     = pos;
            r.kind         = k;
            r.last_of_list = last;
            due_results.insert(due_results.size(), r);
        endfunction

        function void note_byte(t_in_beat beat);
            logic [2:0]  idx;
            logic [31:0] piece;
            logic [31:0] pos;
            logic        more;
            idx  = (slot > LastIndex) ? LastIndex : slot;
            more = beat.data_byte[MoreBit];
            if (skipping) begin
                if (beat.list_end) begin
                    restart_list();
                    push_result(32'd0, KIND_CLOSED, 1'b1);
                end
                return;
            end
            // payload bits shifted past bit 31 fall off here
            piece    = {25'd0, beat.data_byte[6:0]};
            gathered = gathered | (piece << (7 * idx));
            if (!more || beat.list_end) begin
                list_pos = list_pos + gathered;
                pos      = list_pos;
                gathered = '0;
                slot     = '0;
                if (more && idx == LastIndex) begin
                    restart_list();
                    push_result(32'd0, KIND_TOO_LONG, 1'b1);
                end else begin
                    if (beat.list_end) begin
                        restart_list();
                    end
                    push_result(pos, KIND_POSITION, beat.list_end);
                end
            end else if (idx == LastIndex) begin
                gathered = '0;
                slot     = '0;
                skipping = 1'b1;
                push_result(32'd0, KIND_TOO_LONG, 1'b0);
            end else begin
                slot = idx + 3'd1;
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: position %0h kind %0d last %0d",
                       got.position, got.kind, got.last_of_list);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.position !== want.position) begin
                $error("position: expected %0h, actual %0h", want.position, got.position);
                mismatches++;
            end
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.last_of_list !== want.last_of_list) begin
                $error("last_of_list: expected %0d, actual %0d",
                       want.last_of_list, got.last_of_list);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;
    logic      i_out_stall = 1'b0;

    posting_scoreboard sb;
    int beats_sent   = 0;
    bit in_idle_on   = 1'b1;
    bit out_idle_on  = 1'b1;
    bit hold_request = 1'b0;

    delta_varint_posting_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 127);
            1: return $urandom_range(0, 16383);
            2: return $urandom_range(0, 2097151);
            3: return $urandom;
            4: return 32'd0;
            5: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] data, input logic last);
        t_in_beat beat;
        int gap;
        beat.data_byte = data;
        beat.list_end  = last;
        i_in_data  <= beat;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        sb.note_byte(beat);
        beats_sent++;
        gap = in_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // varint of v in at least len bytes; padding zero, fifth byte bits 6:4 random
    task automatic send_value(input logic [31:0] v, input int len, input bit last);
        int n;
        logic [31:0] sh;
        logic [7:0]  b;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0) begin
            n++;
        end
        if (len > n) begin
            n = len;
        end
        for (int k = 0; k < n; k++) begin
            sh = v >> (7 * k);
            b  = {(k < n - 1), sh[6:0]};
            if (k == 4) begin
                b[6:4] = 3'($urandom_range(0, 7));
            end
            send_beat(b, last && (k == n - 1));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_list();
        int choice;
        int nvals;
        int len;
        logic [7:0] rb;
        choice = $urandom_range(0, 99);
        nvals  = $urandom_range(1, 5);
        if (choice < 70) begin
            for (int i = 0; i < nvals; i++) begin
                len = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 5);
                send_value(rand_value(), len, i == nvals - 1);
            end
        end else if (choice < 82) begin
            repeat ($urandom_range(0, 2)) send_value(rand_value(), 0, 1'b0);
            // five beats all asking for more
            repeat (4) begin
                rb = 8'($urandom_range(0, 255));
                rb[MoreBit] = 1'b1;
                send_beat(rb, 1'b0);
            end
            rb = 8'($urandom_range(0, 255));
            rb[MoreBit] = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                send_beat(rb, 1'b1);
            end else begin
                send_beat(rb, 1'b0);
                repeat ($urandom_range(0, 6)) send_beat(8'($urandom_range(0, 255)), 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
        end else if (choice < 92) begin
            repeat ($urandom_range(0, 2)) send_value(rand_value(), 0, 1'b0);
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
                rb = 8'($urandom_range(0, 255));
                rb[MoreBit] = 1'b1;
                send_beat(rb, k == len - 1);
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // result side: check accepted beats, then choose next stall
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                sb.check_result(o_out_data);
            end
            if (hold_request) begin
                hold_left    = HoldCycles;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
                stall_left  = idle_len();
                i_out_stall <= (stall_left > 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest and largest single-beat values
        send_value(32'd0, 1, 1'b0);
        send_value(32'd127, 1, 1'b0);
        // full five-beat value with top payload bits set, then a wrapping delta
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h7F, 1'b0);
        send_value(32'd2, 1, 1'b1);
        // varints cut off by the list end
        send_beat(8'h81, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        // too long mid-list, skipped beat, closing beat
        repeat (5) send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b1);
        // too long on the list end itself
        repeat (4) send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        // redundant continuation beat
        send_beat(8'h80, 1'b0);
        send_beat(8'h00, 1'b1);
        wait_drained();

        while (beats_sent < TotalBeats) begin
            if ($urandom_range(0, 9) == 0) begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (!held && beats_sent > 200) begin
                // back-pressure from the result side while input keeps coming
                held         = 1'b1;
                in_idle_on   = 1'b0;
                hold_request = 1'b1;
                repeat (3) begin
                    for (int i = 0; i < 8; i++) begin
                        send_value($urandom_range(0, 127), 1, i == 7);
                    end
                end
                in_idle_on = 1'b1;
            end
            if (!paused && beats_sent > 400) begin
                paused = 1'b1;
                wait_drained();
            end
            random_list();
        end

        wait_drained();
        repeat (SettleTicks) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/dvpd_pkg.sv
rtl/dvpd_in_reg.sv
rtl/dvpd_decode.sv
rtl/dvpd_out_reg.sv
rtl/delta_varint_posting_decoder_unit.sv
dv/tb_delta_varint_posting_decoder_unit.sv
